/* sv/sal_pkg.sv */
// Package for the sorted array list engine.
// Holds sizes, action and status codes, queue and state types. No dependencies.
package sal_pkg;
  localparam int Capacity = 64;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int DataW = 32;
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REVERSE = 3'd1,
    ACT_PARTITION = 3'd2,
    ACT_READ = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_INSERT, OP_REVERSE, OP_PARTITION, OP_READ, OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t op;
    logic [DataW-1:0] value;
    logic [5:0] index;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
    S_SW_RD, S_SW_RDB, S_SW_CHK, S_SW_WB, S_READ, S_READ_WAIT, S_OUT
  } state_t;
endpackage

/* sv/sorted_array_list_engine_top.sv */
// Top level of the sorted array list engine.
// Depends on sal_pkg, sal_front, sal_back.
//
// Channel   Dir  Fields (tdata low bit up)
// s_axis    in   action[2:0], value[34:3], index[40:35]
// m_axis    out  read_data[31:0], length[38:32], status[40:39]
//
// Insert passes S_SCAN_RD and S_SCAN_CHK per scanned entry and S_SHIFT_RD and
// S_SHIFT_WR per shifted entry; reverse and partition pass S_SW_RD, S_SW_RDB,
// S_SW_CHK and S_SW_WB per swap step, set by the one-port entry memory. Reset
// is synchronous and clears the count and queue. A four-entry queue lets input
// continue while the back end works or waits on m_axis_tready, until it fills.
module sorted_array_list_engine_top import sal_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // action, value, index, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // read_data, length, status, zero fill
);
  logic q_valid, q_pop;
  cmd_t q_cmd;
  logic [DataW-1:0] read_data;
  logic [CountW-1:0] length;
  logic [1:0] status;

  sal_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .action(s_axis_tdata[2:0]), .value(s_axis_tdata[34:3]),
    .index(s_axis_tdata[40:35]), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  sal_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .read_data(read_data), .length(length), .status(status)
  );

  assign m_axis_tdata = {7'd0, status, length, read_data};
endmodule

/* sv/sal_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module sal_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* sv/sal_front.sv */
// Front end: accepts input words, decodes actions and queues commands.
// Depends on sal_pkg.
module sal_front import sal_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  logic [DataW-1:0] value,
  input  logic [5:0] index,
  output logic       q_valid,
  input  logic       q_pop,
  output cmd_t       q_cmd
);
  cmd_t fifo [QDepth];
  logic [QAddrW-1:0] wp, rp;
  logic [QAddrW:0] fill;
  cmd_t dec;
  logic push;

  always_comb begin
    dec.value = value;
    dec.index = index;
    unique case (action)
      ACT_INSERT: dec.op = OP_INSERT;
      ACT_REVERSE: dec.op = OP_REVERSE;
      ACT_PARTITION: dec.op = OP_PARTITION;
      ACT_READ: dec.op = OP_READ;
      ACT_CLEAR: dec.op = OP_CLEAR;
      default: dec.op = OP_NOP;
    endcase
  end

  assign in_ready = fill != (QAddrW+1)'(QDepth);
  assign push = in_valid && in_ready;
  assign q_valid = fill != '0;
  assign q_cmd = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= dec;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
      fill <= fill + (QAddrW+1)'(push) - (QAddrW+1)'(q_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    fill == (QAddrW+1)'(QDepth) |-> !in_ready)
    else $error("ready while queue full");
  assert property (@(posedge clk) disable iff (rst)
    push && !q_pop |=> fill == $past(fill) + 1'b1)
    else $error("fill count slip");
endmodule

/* sv/sal_back.sv */
// Back end: sequencer that carries out list actions on the entry memory.
// Depends on sal_pkg and sal_ram.
module sal_back import sal_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  cmd_t              q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DataW-1:0]  read_data,
  output logic [CountW-1:0] length,
  output logic [1:0]        status
);
  state_t state, state_next;
  cmd_t cmd;
  logic [CountW-1:0] count;
  logic [CountW-1:0] lo, hi, pos;
  logic [DataW-1:0] a_val;
  logic we;
  logic [AddrW-1:0] addr;
  logic [DataW-1:0] wdata, rdata;
  logic wb_second;
  logic swap;

  sal_ram #(.Width(DataW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign q_pop = state == S_IDLE && q_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid) begin
        unique case (q_cmd.op)
          OP_INSERT: state_next = (count >= CountW'(Capacity)) ? S_OUT :
                                  (count == '0) ? S_PUT : S_SCAN_RD;
          OP_REVERSE, OP_PARTITION: state_next = (count < CountW'(2)) ? S_OUT : S_SW_RD;
          OP_READ: state_next = ({1'b0, q_cmd.index} < 7'(count)) ? S_READ : S_OUT;
          default: state_next = S_OUT;
        endcase
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: state_next = ($signed(rdata) < $signed(cmd.value) &&
                               pos + 1'b1 < count) ? S_SCAN_RD :
                               ($signed(rdata) < $signed(cmd.value)) ? S_PUT :
                               S_SHIFT_RD;
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (hi - 1'b1 == pos) ? S_PUT : S_SHIFT_RD;
      S_PUT: state_next = S_OUT;
      S_SW_RD: state_next = S_SW_RDB;
      S_SW_RDB: state_next = S_SW_CHK;
      S_SW_CHK: state_next = S_SW_WB;
      S_SW_WB: state_next = (lo < hi) ? S_SW_RD : S_OUT;
      S_READ: state_next = S_READ_WAIT;
      S_READ_WAIT: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    addr = lo[AddrW-1:0];
    wdata = a_val;
    unique case (state)
      S_SCAN_RD: addr = pos[AddrW-1:0];
      S_SHIFT_RD: addr = AddrW'(hi - 1'b1);
      S_SHIFT_WR: begin we = 1'b1; addr = hi[AddrW-1:0]; wdata = rdata; end
      S_PUT: begin we = 1'b1; addr = pos[AddrW-1:0]; wdata = cmd.value; end
      S_SW_RD: addr = lo[AddrW-1:0];
      S_SW_RDB: addr = hi[AddrW-1:0];
      S_SW_CHK: begin
        we = swap;
        addr = lo[AddrW-1:0];
        wdata = rdata;
      end
      S_SW_WB: begin
        we = wb_second;
        addr = AddrW'(hi + 1'b1);
        wdata = a_val;
      end
      S_READ: addr = cmd.index[AddrW-1:0];
      default: ;
    endcase
  end

  // Swap step: in S_SW_CHK a_val holds entry lo and rdata holds entry hi. Entry lo
  // takes entry hi there when a swap is due, and the old entry hi slot takes a_val
  // in S_SW_WB, after hi has already moved down by one.
  always_comb begin
    swap = 1'b0;
    if (cmd.op == OP_REVERSE) swap = 1'b1;
    else swap = !a_val[0] && rdata[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_ready) out_valid <= 1'b0;
      if (state_next == S_OUT && state != S_OUT) out_valid <= 1'b1;
      if (state == S_PUT) count <= count + 1'b1;
      if (state == S_IDLE && q_valid && q_cmd.op == OP_CLEAR) count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    wb_second <= (state == S_SW_CHK) && swap;
    unique case (state)
      S_IDLE: if (q_valid) begin
        cmd <= q_cmd;
        pos <= '0;
        lo <= '0;
        hi <= count - 1'b1;
        read_data <= '0;
        status <= (q_cmd.op == OP_INSERT && count >= CountW'(Capacity)) ? ST_FULL :
                  (q_cmd.op == OP_READ && !({1'b0, q_cmd.index} < 7'(count))) ?
                  ST_RANGE : ST_DONE;
        length <= (q_cmd.op == OP_CLEAR) ? '0 : count;
      end
      S_SCAN_CHK: begin
        if ($signed(rdata) < $signed(cmd.value)) pos <= pos + 1'b1;
        hi <= count;
      end
      S_SHIFT_WR: hi <= hi - 1'b1;
      S_PUT: length <= count + 1'b1;
      S_SW_RDB: a_val <= rdata;
      S_SW_CHK: begin
        if (swap) begin
          lo <= lo + 1'b1;
          hi <= hi - 1'b1;
        end else if (cmd.op == OP_PARTITION && a_val[0]) begin
          lo <= lo + 1'b1;
        end else begin
          hi <= hi - 1'b1;
        end
      end
      S_READ_WAIT: read_data <= rdata;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) count <= CountW'(Capacity))
    else $error("count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    state == S_PUT |=> count == $past(count) + 1'b1)
    else $error("insert did not grow list");
  assert property (@(posedge clk) disable iff (rst) wb_second |-> state == S_SW_WB)
    else $error("swap write lost");
endmodule
